// ----- hdl/sctf_pkg.sv -----
`default_nettype none
package sctf_pkg;

  // timer geometry
  localparam int TIMER_BITS   = 24;
  localparam int TIMEOUT_MULT = 64;
  localparam int WIDE_W       = TIMER_BITS + 9 + 14;

  // field widths
  localparam int KIND_W   = 2;
  localparam int CODE_W   = 10;
  localparam int ACT_W    = 3;
  localparam int PHASE_W  = 3;
  localparam int T1_W     = 14;
  localparam int T2_W     = 17;
  localparam int T4_W     = 17;
  localparam int LIG_W    = 20;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;

  // results per transaction and queue depth
  localparam int MAX_RES = 4;
  localparam int IDX_W   = $clog2(MAX_RES);
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // input kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  // actions
  localparam logic [ACT_W-1:0] ACT_SEND_REQ = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SEND_ACK = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PASS     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TIMEOUT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FAIL     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_TERM     = 3'd5;

  // transaction phases
  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CALL = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PROC = 3'd2;
  localparam logic [PHASE_W-1:0] PH_COMP = 3'd3;
  localparam logic [PHASE_W-1:0] PH_TERM = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_T1  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T4  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIG = 2'd3;

  localparam logic [WIDE_W-1:0] TMAX_W = (WIDE_W'(1) << TIMER_BITS) - WIDE_W'(1);

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  // all results of one transaction
  typedef struct packed {
    logic [CNT_W-1:0]              cnt;
    logic [MAX_RES-1:0][ACT_W-1:0] acts;
    logic [CODE_W-1:0]             code;
    logic [PHASE_W-1:0]            phase;
  } bundle_t;

  function automatic logic [TIMER_BITS-1:0] sat(input logic [WIDE_W-1:0] v);
    return (v > TMAX_W) ? TMAX_W[TIMER_BITS-1:0] : v[TIMER_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sctf_in_if.sv -----
`default_nettype none
interface sctf_in_if;
  logic                        valid;
  logic                        ready;
  logic [sctf_pkg::KIND_W-1:0] kind;
  logic                        is_invite;
  logic                        unreliable;
  logic [sctf_pkg::CODE_W-1:0] status_code;
  logic                        send_failed;

  modport source (output valid, kind, is_invite, unreliable, status_code, send_failed,
                  input ready);
  modport sink (input valid, kind, is_invite, unreliable, status_code, send_failed,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/sctf_out_if.sv -----
`default_nettype none
interface sctf_out_if;
  logic                         valid;
  logic                         ready;
  logic [sctf_pkg::ACT_W-1:0]   action;
  logic [sctf_pkg::CODE_W-1:0]  code_out;
  logic [sctf_pkg::PHASE_W-1:0] phase;
  logic                         last;

  modport source (output valid, action, code_out, phase, last, input ready);
  modport sink (input valid, action, code_out, phase, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/sctf_front.sv -----
`default_nettype none
module sctf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  sctf_pkg::cfg_wr_t cfg,
  sctf_in_if.sink           in_ch,
  input  logic              q_full,
  output logic              push,
  output sctf_pkg::bundle_t bundle
);
  import sctf_pkg::*;

  // configuration
  logic [T1_W-1:0]  t1_r;
  logic [T2_W-1:0]  t2_r;
  logic [T4_W-1:0]  t4_r;
  logic [LIG_W-1:0] lig_r;

  // transaction state
  logic [PHASE_W-1:0]    phase_r, phase_nxt;
  logic                  inv_r, inv_nxt;
  logic                  unrel_r, unrel_nxt;
  logic [TIMER_BITS-1:0] rint_r, rint_nxt;
  logic [TIMER_BITS-1:0] rcnt_r, rcnt_nxt;
  logic                  ract_r, ract_nxt;
  logic [TIMER_BITS-1:0] tcnt_r, tcnt_nxt;
  logic                  tact_r, tact_nxt;

  // step scratch
  logic [CNT_W-1:0]              n_c;
  logic [MAX_RES-1:0][ACT_W-1:0] acts_c;
  logic [CODE_W-1:0]             code_c;
  logic                          term_c;
  logic                          comp_c;
  logic [WIDE_W-1:0]             lin_c;
  logic [WIDE_W-1:0]             t1e_w;
  logic [WIDE_W-1:0]             t2e_w;
  logic [WIDE_W-1:0]             dbl_w;
  logic [TIMER_BITS-1:0]         tdec_c;
  logic [TIMER_BITS-1:0]         rdec_c;
  logic [TIMER_BITS-1:0]         nint_c;
  logic                          prov_c, ok_c, fail_c;
  logic                          sf_c;
  logic                          acc;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign sf_c        = in_ch.send_failed;

  assign t1e_w  = (t1_r == '0) ? WIDE_W'(1) : WIDE_W'(t1_r);
  assign t2e_w  = (t2_r == '0) ? WIDE_W'(1) : WIDE_W'(t2_r);
  assign dbl_w  = WIDE_W'({rint_r, 1'b0});
  assign tdec_c = (tcnt_r != '0) ? tcnt_r - 1'b1 : '0;
  assign rdec_c = (rcnt_r != '0) ? rcnt_r - 1'b1 : '0;

  assign prov_c = (in_ch.status_code >= CODE_W'(100)) && (in_ch.status_code <= CODE_W'(199));
  assign ok_c   = (in_ch.status_code >= CODE_W'(200)) && (in_ch.status_code <= CODE_W'(299));
  assign fail_c = (in_ch.status_code >= CODE_W'(300)) && (in_ch.status_code <= CODE_W'(699));

  // next retransmit interval after a resend
  always_comb begin
    if (inv_r) begin
      nint_c = sat(dbl_w);
    end else if (phase_r == PH_CALL) begin
      nint_c = sat((dbl_w < t2e_w) ? dbl_w : t2e_w);
    end else begin
      nint_c = sat(t2e_w);
    end
    if (nint_c == '0) nint_c = TIMER_BITS'(1);
  end

  // classify the transaction and work out the state step and its actions
  always_comb begin
    phase_nxt = phase_r;
    inv_nxt   = inv_r;
    unrel_nxt = unrel_r;
    rint_nxt  = rint_r;
    rcnt_nxt  = rcnt_r;
    ract_nxt  = ract_r;
    tcnt_nxt  = tcnt_r;
    tact_nxt  = tact_r;
    n_c       = '0;
    acts_c    = '0;
    code_c    = '0;
    term_c    = 1'b0;
    comp_c    = 1'b0;
    lin_c     = '0;
    case (in_ch.kind)
      KIND_START: begin
        if (phase_r == PH_IDLE || phase_r == PH_TERM) begin
          inv_nxt   = in_ch.is_invite;
          unrel_nxt = in_ch.unreliable;
          phase_nxt = PH_CALL;
          ract_nxt  = 1'b0;
          tact_nxt  = 1'b0;
          acts_c[n_c[IDX_W-1:0]] = ACT_SEND_REQ;
          n_c = n_c + 1'b1;
          if (sf_c) begin
            acts_c[n_c[IDX_W-1:0]] = ACT_FAIL;
            n_c = n_c + 1'b1;
            term_c = 1'b1;
          end else begin
            rint_nxt = sat(t1e_w);
            rcnt_nxt = sat(t1e_w);
            ract_nxt = in_ch.unreliable;
            tcnt_nxt = sat(t1e_w * WIDE_W'(TIMEOUT_MULT));
            tact_nxt = 1'b1;
          end
        end
      end
      KIND_RESP: begin
        if (prov_c || ok_c || fail_c) begin
          if (phase_r == PH_COMP) begin
            // resend the ACK for a repeated final failure
            if (inv_r && fail_c) begin
              acts_c[n_c[IDX_W-1:0]] = ACT_SEND_ACK;
              n_c = n_c + 1'b1;
              if (sf_c) begin
                acts_c[n_c[IDX_W-1:0]] = ACT_FAIL;
                n_c = n_c + 1'b1;
                term_c = 1'b1;
              end
            end
          end else if (phase_r == PH_CALL || phase_r == PH_PROC) begin
            acts_c[n_c[IDX_W-1:0]] = ACT_PASS;
            n_c    = n_c + 1'b1;
            code_c = in_ch.status_code;
            if (inv_r) begin
              ract_nxt = 1'b0;
              if (prov_c) begin
                phase_nxt = PH_PROC;
                tact_nxt  = 1'b0;
              end else if (ok_c) begin
                term_c = 1'b1;
              end else begin
                acts_c[n_c[IDX_W-1:0]] = ACT_SEND_ACK;
                n_c = n_c + 1'b1;
                if (sf_c) begin
                  acts_c[n_c[IDX_W-1:0]] = ACT_FAIL;
                  n_c = n_c + 1'b1;
                  term_c = 1'b1;
                end else begin
                  comp_c = 1'b1;
                  lin_c  = unrel_r ? WIDE_W'(lig_r) : '0;
                end
              end
            end else begin
              if (prov_c) begin
                phase_nxt = PH_PROC;
              end else begin
                comp_c = 1'b1;
                lin_c  = unrel_r ? WIDE_W'(t4_r) : '0;
              end
            end
          end
        end
      end
      KIND_TICK: begin
        if (phase_r == PH_COMP) begin
          // linger countdown
          if (tact_r) begin
            tcnt_nxt = tdec_c;
            if (tdec_c == '0) term_c = 1'b1;
          end
        end else if (phase_r == PH_CALL || phase_r == PH_PROC) begin
          if (tact_r) tcnt_nxt = tdec_c;
          if (ract_r) rcnt_nxt = rdec_c;
          if (tact_r && tdec_c == '0) begin
            acts_c[n_c[IDX_W-1:0]] = ACT_TIMEOUT;
            n_c = n_c + 1'b1;
            term_c = 1'b1;
          end else if (ract_r && rdec_c == '0) begin
            acts_c[n_c[IDX_W-1:0]] = ACT_SEND_REQ;
            n_c = n_c + 1'b1;
            if (sf_c) begin
              acts_c[n_c[IDX_W-1:0]] = ACT_FAIL;
              n_c = n_c + 1'b1;
              term_c = 1'b1;
            end else begin
              rint_nxt = nint_c;
              rcnt_nxt = nint_c;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // enter Completed, or terminate at once on zero linger
    if (comp_c) begin
      ract_nxt = 1'b0;
      tact_nxt = 1'b0;
      if (lin_c == '0) begin
        term_c = 1'b1;
      end else begin
        phase_nxt = PH_COMP;
        tcnt_nxt  = sat(lin_c);
        tact_nxt  = 1'b1;
      end
    end

    // terminate: always the final action
    if (term_c) begin
      phase_nxt = PH_TERM;
      ract_nxt  = 1'b0;
      tact_nxt  = 1'b0;
      acts_c[n_c[IDX_W-1:0]] = ACT_TERM;
      n_c = n_c + 1'b1;
    end
  end

  assign push         = acc && (n_c != '0);
  assign bundle.cnt   = n_c;
  assign bundle.acts  = acts_c;
  assign bundle.code  = code_c;
  assign bundle.phase = phase_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r  <= T1_W'(500);
      t2_r  <= T2_W'(4000);
      t4_r  <= T4_W'(5000);
      lig_r <= LIG_W'(32000);
    end else if (cfg.we) begin
      case (cfg.idx)
        REG_T1:  t1_r  <= cfg.data[T1_W-1:0];
        REG_T2:  t2_r  <= cfg.data[T2_W-1:0];
        REG_T4:  t4_r  <= cfg.data[T4_W-1:0];
        REG_LIG: lig_r <= cfg.data[LIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // advance the transaction state on every accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      inv_r   <= 1'b0;
      unrel_r <= 1'b0;
      rint_r  <= '0;
      rcnt_r  <= '0;
      ract_r  <= 1'b0;
      tcnt_r  <= '0;
      tact_r  <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      inv_r   <= inv_nxt;
      unrel_r <= unrel_nxt;
      rint_r  <= rint_nxt;
      rcnt_r  <= rcnt_nxt;
      ract_r  <= ract_nxt;
      tcnt_r  <= tcnt_nxt;
      tact_r  <= tact_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sctf_queue.sv -----
`default_nettype none
module sctf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sctf_pkg::bundle_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output sctf_pkg::bundle_t rdata
);
  import sctf_pkg::*;

  bundle_t           mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(Q_DEPTH));
  assign avail = (cnt_r != '0);
  assign rdata = mem[rd_r];

  // pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt  = (wr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      cnt_nxt = cnt_nxt + 1'b1;
    end
    if (pop) begin
      rd_nxt  = (rd_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      cnt_nxt = cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // store the transaction bundle
  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= wdata;
  end

endmodule
`default_nettype wire

// ----- hdl/sctf_back.sv -----
`default_nettype none
module sctf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_avail,
  input  sctf_pkg::bundle_t q_data,
  output logic              q_pop,
  sctf_out_if.source        out_ch
);
  import sctf_pkg::*;

  bundle_t          cur_r;
  logic [IDX_W-1:0] idx_r;
  logic             busy_r;
  logic             fire;
  logic             is_last;

  assign is_last = (CNT_W'(idx_r) == cur_r.cnt - 1'b1);
  assign fire    = out_ch.valid && out_ch.ready;
  assign q_pop   = q_avail && (!busy_r || (fire && is_last));

  // drive the current result
  assign out_ch.valid    = busy_r;
  assign out_ch.action   = cur_r.acts[idx_r];
  assign out_ch.code_out = (cur_r.acts[idx_r] == ACT_PASS) ? cur_r.code : '0;
  assign out_ch.phase    = cur_r.phase;
  assign out_ch.last     = is_last;

  // load the next bundle or advance within the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (fire) begin
      if (is_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
  end

endmodule
`default_nettype wire

// ----- hdl/sip_client_transaction_fsm_unit.sv -----
`default_nettype none
// SIP client transaction engine. Feed it start, response and one-millisecond
// tick transactions; it returns one to four actions per transaction (send
// request, send ACK, pass response, timeout, send failure, terminated), one
// per cycle while the output is ready, the last one flagged. The front stage
// takes a transaction in every cycle while the queue is not full and updates
// the transaction state in that cycle; a four-entry queue of action bundles
// sits before the output stage, so the actions of each transaction leave the
// single output port one after another. Items causing no action produce
// nothing. The user must write timer registers through cfg_we/cfg_idx/cfg_data
// only while the block is idle; the block itself does not enforce this.
module sip_client_transaction_fsm_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  sctf_in_if.sink                        in_ch,
  sctf_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [sctf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sctf_pkg::CFG_W-1:0]     cfg_data
);
  import sctf_pkg::*;

  cfg_wr_t cfg;
  bundle_t f_bundle;
  bundle_t q_data;
  logic    f_push;
  logic    q_full;
  logic    q_avail;
  logic    q_pop;

  assign cfg.we   = cfg_we;
  assign cfg.idx  = cfg_idx;
  assign cfg.data = cfg_data;

  sctf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (f_push),
    .bundle (f_bundle)
  );

  sctf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_bundle),
    .full  (q_full),
    .pop   (q_pop),
    .avail (q_avail),
    .rdata (q_data)
  );

  sctf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_avail (q_avail),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // terminated closes the transaction's actions and reports the final phase
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.action == ACT_TERM) |-> (out_ch.last && out_ch.phase == PH_TERM))
    else $error("terminated action not last or phase not terminated");

  // a taken action that is not last is followed by another
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid)
    else $error("action bundle cut short");
`endif

endmodule
`default_nettype wire

// ----- dv/sctf_tb_pkg.sv -----
package sctf_tb_pkg;
  import sctf_pkg::*;

  // kind value with no meaning, used as noise
  localparam logic [KIND_W-1:0] KIND_VOID = 2'd3;
  localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_invite;
    logic              unreliable;
    logic [CODE_W-1:0] status_code;
    logic              send_failed;
  } txn_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [CODE_W-1:0]  code;
    logic [PHASE_W-1:0] phase;
    logic               last;
  } action_rec_t;

  // Tracks the transaction state and timers, queues the actions due.
  class sip_txn_scoreboard;
    longint unsigned    t1_ms, t2_ms, t4_ms, linger_ms;
    logic [PHASE_W-1:0] phase_q;
    bit                 invite_q, unrel_q, retx_on, tmo_on, refuse_send;
    longint unsigned    retx_ivl, retx_left, tmo_left;
    action_rec_t        due_actions[$];
    action_rec_t        step_actions[$];
    int                 n_bad;

    function new();
      t1_ms     = 500;
      t2_ms     = 4000;
      t4_ms     = 5000;
      linger_ms = 32000;
      phase_q   = PH_IDLE;
      invite_q  = 0;
      unrel_q   = 0;
      retx_on   = 0;
      tmo_on    = 0;
      retx_ivl  = 0;
      retx_left = 0;
      tmo_left  = 0;
      n_bad     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_T1:  t1_ms     = data[T1_W-1:0];
        REG_T2:  t2_ms     = data[T2_W-1:0];
        REG_T4:  t4_ms     = data[T4_W-1:0];
        REG_LIG: linger_ms = data[LIG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned clamp_timer(longint unsigned v);
      return (v > TIMER_MAX) ? TIMER_MAX : v;
    endfunction

    // zero intervals behave as one millisecond
    function longint unsigned base_t1();
      return (t1_ms == 0) ? 1 : t1_ms;
    endfunction

    function longint unsigned base_t2();
      return (t2_ms == 0) ? 1 : t2_ms;
    endfunction

    function void emit_action(logic [ACT_W-1:0] a, logic [CODE_W-1:0] c);
      action_rec_t r;
      if (step_actions.size() < MAX_RES) begin
        r        = '0;
        r.action = a;
        r.code   = c;
        step_actions.push_back(r);
      end
    endfunction

    function void enter_terminated();
      phase_q = PH_TERM;
      retx_on = 0;
      tmo_on  = 0;
      emit_action(ACT_TERM, '0);
    endfunction

    // a refused send is followed by failure and termination
    function bit try_send(logic [ACT_W-1:0] a);
      emit_action(a, '0);
      if (refuse_send) begin
        emit_action(ACT_FAIL, '0);
        enter_terminated();
        return 0;
      end
      return 1;
    endfunction

    function void enter_completed(longint unsigned linger);
      retx_on = 0;
      tmo_on  = 0;
      if (linger == 0) begin
        enter_terminated();
        return;
      end
      phase_q  = PH_COMP;
      tmo_left = clamp_timer(linger);
      tmo_on   = 1;
    endfunction

    function void start_txn(bit inv, bit unrel);
      if (phase_q != PH_IDLE && phase_q != PH_TERM) return;
      invite_q = inv;
      unrel_q  = unrel;
      phase_q  = PH_CALL;
      retx_on  = 0;
      tmo_on   = 0;
      if (!try_send(ACT_SEND_REQ)) return;
      retx_ivl  = clamp_timer(base_t1());
      retx_left = retx_ivl;
      retx_on   = unrel;
      tmo_left  = clamp_timer(base_t1() * TIMEOUT_MULT);
      tmo_on    = 1;
    endfunction

    function void take_response(logic [CODE_W-1:0] code);
      bit prov, ok, fail;
      prov = (code >= 100) && (code <= 199);
      ok   = (code >= 200) && (code <= 299);
      fail = (code >= 300) && (code <= 699);
      if (!(prov || ok || fail)) return;
      // INVITE failures retransmitted by the server get the ACK again
      if (phase_q == PH_COMP) begin
        if (invite_q && fail) void'(try_send(ACT_SEND_ACK));
        return;
      end
      if (phase_q != PH_CALL && phase_q != PH_PROC) return;
      if (invite_q) begin
        retx_on = 0;
        if (prov) begin
          phase_q = PH_PROC;
          tmo_on  = 0;
          emit_action(ACT_PASS, code);
        end else if (ok) begin
          emit_action(ACT_PASS, code);
          enter_terminated();
        end else begin
          emit_action(ACT_PASS, code);
          if (try_send(ACT_SEND_ACK)) enter_completed(unrel_q ? linger_ms : 0);
        end
      end else begin
        emit_action(ACT_PASS, code);
        if (prov) phase_q = PH_PROC;
        else enter_completed(unrel_q ? t4_ms : 0);
      end
    endfunction

    function void advance_ms();
      bit              tmo_hit, retx_hit;
      longint unsigned dbl;
      tmo_hit  = 0;
      retx_hit = 0;
      // linger countdown
      if (phase_q == PH_COMP) begin
        if (tmo_on) begin
          if (tmo_left > 0) tmo_left--;
          if (tmo_left == 0) enter_terminated();
        end
        return;
      end
      if (phase_q != PH_CALL && phase_q != PH_PROC) return;
      if (tmo_on) begin
        if (tmo_left > 0) tmo_left--;
        tmo_hit = (tmo_left == 0);
      end
      if (retx_on) begin
        if (retx_left > 0) retx_left--;
        retx_hit = (retx_left == 0);
      end
      // timeout wins over a retransmission due on the same tick
      if (tmo_hit) begin
        emit_action(ACT_TIMEOUT, '0);
        enter_terminated();
        return;
      end
      if (!retx_hit) return;
      if (!try_send(ACT_SEND_REQ)) return;
      if (invite_q) begin
        retx_ivl = clamp_timer(retx_ivl * 2);
      end else if (phase_q == PH_CALL) begin
        dbl      = retx_ivl * 2;
        retx_ivl = clamp_timer((dbl < base_t2()) ? dbl : base_t2());
      end else begin
        retx_ivl = clamp_timer(base_t2());
      end
      if (retx_ivl == 0) retx_ivl = 1;
      retx_left = retx_ivl;
    endfunction

    // predict the actions of one accepted transaction
    function void note_input(txn_item_t it);
      step_actions.delete();
      refuse_send = it.send_failed;
      case (it.kind)
        KIND_START: start_txn(it.is_invite, it.unreliable);
        KIND_RESP:  take_response(it.status_code);
        KIND_TICK:  advance_ms();
        default:    ;
      endcase
      foreach (step_actions[k]) begin
        step_actions[k].phase = phase_q;
        step_actions[k].last  = (k == step_actions.size() - 1);
        due_actions.push_back(step_actions[k]);
      end
    endfunction

    function void log_bad(string what, action_rec_t want, action_rec_t got);
      n_bad++;
      if (n_bad <= 10)
        $display("%s: act/code/phase/last got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d",
                 what, got.action, got.code, got.phase, got.last,
                 want.action, want.code, want.phase, want.last);
    endfunction

    function void check_result(action_rec_t got);
      action_rec_t want;
      if (due_actions.size() == 0) begin
        log_bad("unexpected action", '0, got);
        return;
      end
      want = due_actions.pop_front();
      if (got !== want) log_bad("action mismatch", want, got);
    endfunction

    function int pending();
      return due_actions.size();
    endfunction

    function int failures();
      return n_bad;
    endfunction
  endclass

endpackage

// ----- dv/tb_sip_client_transaction_fsm_unit.sv -----
module tb_sip_client_transaction_fsm_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sctf_pkg::*;
  import sctf_tb_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 120;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  sctf_in_if  in_ch();
  sctf_out_if out_ch();

  sip_txn_scoreboard sb;
  bit                idle_en;
  bit                hold_req;
  bit                ep_silent;

  sip_client_transaction_fsm_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stall bursts and the long hold-off
  initial begin
    int stall;
    stall        = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else if (stall == 0 && idle_en && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 17);
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // check every accepted action
  always @(posedge clk) begin
    action_rec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.action = out_ch.action;
      got.code   = out_ch.code_out;
      got.phase  = out_ch.phase;
      got.last   = out_ch.last;
      sb.check_result(got);
    end
  end

  function automatic txn_item_t mk_item(logic [KIND_W-1:0] kind, logic inv, logic unrel,
                                        logic [CODE_W-1:0] code, logic fail);
    txn_item_t it;
    it.kind        = kind;
    it.is_invite   = inv;
    it.unreliable  = unrel;
    it.status_code = code;
    it.send_failed = fail;
    return it;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code(bit in_comp);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      if (r < 3) return CODE_W'($urandom_range(0, 99));
      return CODE_W'($urandom_range(700, 1023));
    end
    if (in_comp) begin
      if (r < 80) return CODE_W'($urandom_range(300, 699));
      return CODE_W'($urandom_range(100, 299));
    end
    if (r < 40) return CODE_W'($urandom_range(100, 199));
    if (r < 65) return CODE_W'($urandom_range(200, 299));
    return CODE_W'($urandom_range(300, 699));
  endfunction

  // mostly well-formed episodes, some noise; silent episodes run into timeout
  function automatic void gen_item(output txn_item_t it, output bit useful);
    int unsigned        r;
    logic [PHASE_W-1:0] ph;
    ph     = sb.phase_q;
    r      = $urandom_range(0, 99);
    it     = mk_item(KIND_VOID, 1'($urandom), 1'($urandom), CODE_W'($urandom),
                     $urandom_range(0, 11) == 0);
    useful = 1'b0;
    if (ph == PH_IDLE || ph == PH_TERM) begin
      if (r < 85) begin
        it.kind       = KIND_START;
        it.unreliable = ($urandom_range(0, 9) < 7);
        ep_silent     = (sb.base_t1() <= 2) && ($urandom_range(0, 4) == 0);
        useful        = 1'b1;
      end else if (r < 92) begin
        it.kind = KIND_TICK;
      end else if (r < 97) begin
        it.kind = KIND_RESP;
      end
    end else if (r < 5) begin
      it.kind = (r < 3) ? KIND_START : KIND_VOID;
    end else if ((ep_silent && ph == PH_CALL) || r < 70) begin
      it.kind = KIND_TICK;
      useful  = 1'b1;
    end else begin
      it.kind        = KIND_RESP;
      it.status_code = pick_code(ph == PH_COMP);
      useful         = (it.status_code >= 100) && (it.status_code <= 699);
    end
  endfunction

  task automatic send_item(txn_item_t it);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.kind        = it.kind;
    in_ch.is_invite   = it.is_invite;
    in_ch.unreliable  = it.unreliable;
    in_ch.status_code = it.status_code;
    in_ch.send_failed = it.send_failed;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  // stop offering, wait for every action, let the pipeline settle
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    sb.write_reg(idx, data);
  endtask

  task automatic set_timers(int t1, int t2, int t4, int lig);
    write_reg(REG_T1, CFG_W'(t1));
    write_reg(REG_T2, CFG_W'(t2));
    write_reg(REG_T4, CFG_W'(t4));
    write_reg(REG_LIG, CFG_W'(lig));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_random(int n);
    int        done;
    txn_item_t it;
    bit        useful;
    done = 0;
    while (done < n) begin
      gen_item(it, useful);
      send_item(it);
      if (useful) done++;
    end
  endtask

  // bring the transaction to idle or terminated, then flood while the output is held
  task automatic fill_under_hold();
    while (sb.phase_q != PH_IDLE && sb.phase_q != PH_TERM) begin
      if (sb.phase_q == PH_PROC && sb.invite_q)
        send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(200), 1'b0));
      else
        send_item(mk_item(KIND_TICK, 1'b0, 1'b0, '0, 1'b0));
    end
    hold_req = 1'b1;
    repeat (10) send_item(mk_item(KIND_START, 1'($urandom), 1'($urandom), '0, 1'b1));
  endtask

  initial begin
    sb                = new();
    idle_en           = 1'b1;
    hold_req          = 1'b0;
    ep_silent         = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_T1;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_START;
    in_ch.is_invite   = 1'b0;
    in_ch.unreliable  = 1'b0;
    in_ch.status_code = '0;
    in_ch.send_failed = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset timer values
    send_item(mk_item(KIND_VOID, 1'b1, 1'b1, CODE_W'(1023), 1'b1));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(200), 1'b0));
    send_item(mk_item(KIND_TICK, 1'b0, 1'b0, '0, 1'b0));
    send_item(mk_item(KIND_START, 1'b0, 1'b0, '0, 1'b0));
    send_item(mk_item(KIND_START, 1'b1, 1'b1, '0, 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(0), 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(99), 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(700), 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(100), 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(199), 1'b0));
    send_item(mk_item(KIND_TICK, 1'b0, 1'b0, '0, 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(299), 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(200), 1'b0));
    send_item(mk_item(KIND_START, 1'b1, 1'b1, '0, 1'b1));
    send_item(mk_item(KIND_START, 1'b1, 1'b1, '0, 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(699), 1'b1));
    send_item(mk_item(KIND_START, 1'b1, 1'b0, '0, 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(180), 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(200), 1'b0));
    send_item(mk_item(KIND_START, 1'b1, 1'b0, '0, 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(300), 1'b0));
    drain_results();

    // directed: INVITE retransmit, Completed with ACK resend and short linger
    set_timers(1, 2, 3, 4);
    send_item(mk_item(KIND_START, 1'b1, 1'b1, '0, 1'b0));
    send_item(mk_item(KIND_TICK, 1'b0, 1'b0, '0, 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(486), 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(600), 1'b0));
    send_item(mk_item(KIND_RESP, 1'b0, 1'b0, CODE_W'(180), 1'b0));
    repeat (4) send_item(mk_item(KIND_TICK, 1'b0, 1'b0, '0, 1'b0));
    drain_results();

    // low extremes, zero lingers, output held while input floods
    set_timers(1, 1, 0, 0);
    fill_under_hold();
    run_random(70);
    drain_results();

    set_timers(2, 8, 5, 12);
    run_random(70);
    drain_results();

    // zero base intervals behave as one
    set_timers(0, 0, 2, 9);
    run_random(60);
    drain_results();

    set_timers(10000, 100000, 1, 2);
    run_random(40);
    drain_results();

    set_timers($urandom_range(1, 3), $urandom_range(1, 10), $urandom_range(0, 8),
               $urandom_range(0, 16));
    run_random(70);
    drain_results();

    // high extremes, no idling to the end
    idle_en = 1'b0;
    set_timers(3, 100000, 100000, 1000000);
    run_random(50);
    drain_results();

    if (sb.failures() == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
